// File: rtl/core/wsd_pkg.sv
// shared types and constants of the wake score smoother and debouncer
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // default ring depth
  localparam int WINDOW_DEF = 8;

  // fixed field widths
  localparam int CODE_W   = 8;
  localparam int SCORE_W  = 9;
  localparam int MARGIN_W = 8;
  localparam int HIT_W    = 4;
  localparam int CFG_W    = 9;
  localparam int QUOT_W   = 8;
  localparam logic [HIT_W-1:0] HIT_MAX = 4'd15;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CODE_OFFSET    = 2'd0,
    CFG_WAKE_THRESHOLD = 2'd1,
    CFG_KEYWORD_MARGIN = 2'd2,
    CFG_HITS_NEEDED    = 2'd3
  } cfg_index_t;

  // request operations
  typedef enum logic {
    OP_SCORE = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // input request payload
  typedef struct packed {
    op_t                      operation;
    logic signed [CODE_W-1:0] keyword_code;
    logic signed [CODE_W-1:0] unknown_code;
    logic signed [CODE_W-1:0] silence_code;
    logic                     verify_ok;
  } score_t;

  // result payload
  typedef struct packed {
    logic signed [SCORE_W-1:0] smoothed_score;
    logic                      awake;
    logic                      rejected;
  } result_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CMP,
    ST_DIV,
    ST_FIN
  } seq_state_t;

  // controls towards the debounce counter
  typedef struct packed {
    logic clear;
    logic update;
    logic hit;
    logic verify_ok;
  } deb_req_t;

  // decision from the debounce counter
  typedef struct packed {
    logic awake;
    logic rejected;
  } deb_res_t;

endpackage

`default_nettype wire

// File: rtl/core/wsd_debounce.sv
// consecutive hit counter with awake and verifier reject decision
`timescale 1ns / 1ps
`default_nettype none

module wsd_debounce import wsd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [HIT_W-1:0] hits_needed,
  input  wire deb_req_t         req,
  output deb_res_t              res
);

  logic [HIT_W-1:0] hit_count;
  logic [HIT_W-1:0] hit_count_next;
  logic             awake_raw;

  // saturating count of consecutive hits, zero on a miss
  always_comb begin
    if (req.hit) begin
      hit_count_next = (hit_count == HIT_MAX) ? hit_count : hit_count + 1'b1;
    end else begin
      hit_count_next = '0;
    end
    awake_raw    = (hit_count_next >= hits_needed);
    res.awake    = awake_raw & req.verify_ok;
    res.rejected = awake_raw & ~req.verify_ok;
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      hit_count <= '0;
    end else if (req.update) begin
      hit_count <= hit_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wake_score_smoother_debouncer.sv
// wake score smoother and debouncer, top level
//
//   channel   direction  handshake                   payload
//   score     in         score_valid / score_stall   score  (score_t)
//   result    out        result_valid / result_stall result (result_t)
//   config    in         cfg_we                      cfg_index, cfg_data
//
// a score request, from acceptance to a ready result, makes one ring read per
// filled entry (up to 8 at the default window) through the shared adder, one
// threshold compare, then 8 restoring divide steps
// a clear request empties the ring and the hit count and gives no result
// reset (rst, synchronous) empties the ring and the hit count, restores registers
// score_stall is high while a request is in work or its result cannot be
// placed; the result register holds while result_stall is high
`timescale 1ns / 1ps
`default_nettype none

module wake_score_smoother_debouncer import wsd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             score_valid,
  output logic                  score_stall,
  input  wire score_t           score,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int ACC_W  = SCORE_W + CNT_W;
  localparam int ALU_W  = ACC_W + 1;
  localparam int STEP_W = $clog2(QUOT_W);

  // configuration registers
  logic signed [CODE_W-1:0]  code_offset;
  logic signed [SCORE_W-1:0] wake_threshold;
  logic [MARGIN_W-1:0]       keyword_margin;
  logic [HIT_W-1:0]          hits_needed;

  // ring and its pointers
  logic signed [SCORE_W-1:0] ring [WINDOW];
  logic [IDX_W-1:0]          write_slot;
  logic [CNT_W-1:0]          fill_count;
  logic [CNT_W-1:0]          rd_idx;
  logic signed [SCORE_W-1:0] rd_data;
  logic                      rd_vld;

  // datapath registers
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   prod;
  logic [ACC_W-1:0]          rem;
  logic [ACC_W-1:0]          div;
  logic [QUOT_W-1:0]         quot;
  logic [STEP_W-1:0]         step;
  logic                      neg;
  logic                      hit_sum;
  logic                      code_ok;
  logic                      item_ok;

  seq_state_t state;
  seq_state_t state_next;

  logic accept;
  logic fire;
  logic signed [ALU_W-1:0] alu_a;
  logic signed [ALU_W-1:0] alu_b;
  logic signed [ALU_W-1:0] alu_y;
  logic                    alu_sub;
  logic signed [SCORE_W-1:0]  shifted_kw;
  logic signed [SCORE_W+1:0]  kw_wide;
  logic signed [SCORE_W+1:0]  un_plus_margin;
  logic signed [SCORE_W-1:0]  mean;
  deb_req_t deb_req;
  deb_res_t deb_res;

  // request decode and code comparisons
  always_comb begin
    accept         = score_valid && !score_stall;
    shifted_kw     = SCORE_W'(score.keyword_code) - SCORE_W'(code_offset);
    kw_wide        = (SCORE_W + 2)'(score.keyword_code);
    un_plus_margin = (SCORE_W + 2)'(score.unknown_code)
                   + $signed((SCORE_W + 2)'(keyword_margin));
    mean           = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  // shared add / subtract unit
  always_comb begin
    case (state)
      ST_SUM: begin
        alu_a   = ALU_W'(acc);
        alu_b   = ALU_W'(rd_data);
        alu_sub = 1'b0;
      end
      ST_CMP: begin
        alu_a   = ALU_W'(acc);
        alu_b   = ALU_W'(prod);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = $signed({1'b0, rem});
        alu_b   = $signed({1'b0, div});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = ALU_W'(acc);
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // sequencer next state and strobes
  always_comb begin
    state_next  = state;
    score_stall = (state != ST_IDLE);
    fire        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && score.operation == OP_SCORE) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (rd_idx == fill_count && !rd_vld) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_W'(QUOT_W - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!result_valid || !result_stall) begin
          fire       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      code_offset    <= -8'sd128;
      wake_threshold <= 9'sd128;
      keyword_margin <= '0;
      hits_needed    <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODE_OFFSET:    code_offset    <= cfg_data[CODE_W-1:0];
        CFG_WAKE_THRESHOLD: wake_threshold <= cfg_data[SCORE_W-1:0];
        CFG_KEYWORD_MARGIN: keyword_margin <= cfg_data[MARGIN_W-1:0];
        CFG_HITS_NEEDED:    hits_needed    <= cfg_data[HIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ring write and pointer control
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (accept) begin
      if (score.operation == OP_CLEAR) begin
        write_slot <= '0;
        fill_count <= '0;
      end else begin
        write_slot <= (write_slot == IDX_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
        if (fill_count != CNT_W'(WINDOW)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (accept && score.operation == OP_SCORE) begin
      ring[write_slot] <= shifted_kw;
    end
    rd_data <= ring[rd_idx[IDX_W-1:0]];
  end

  // summing, threshold compare and divide steps
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          rd_idx  <= '0;
          rd_vld  <= 1'b0;
          acc     <= '0;
          code_ok <= (kw_wide >= un_plus_margin)
                   && (score.keyword_code >= score.silence_code);
          item_ok <= score.verify_ok;
        end
        ST_SUM: begin
          prod <= ACC_W'($signed(wake_threshold) * $signed({1'b0, fill_count}));
          if (rd_vld) begin
            acc <= alu_y[ACC_W-1:0];
          end
          if (rd_idx != fill_count) begin
            rd_idx <= rd_idx + 1'b1;
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
        end
        ST_CMP: begin
          hit_sum <= !alu_y[ALU_W-1];
          neg     <= acc[ACC_W-1];
          rem     <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
          div     <= ACC_W'(fill_count) << (QUOT_W - 1);
          quot    <= '0;
          step    <= '0;
        end
        ST_DIV: begin
          if (!alu_y[ALU_W-1]) begin
            rem <= alu_y[ACC_W-1:0];
          end
          quot <= {quot[QUOT_W-2:0], !alu_y[ALU_W-1]};
          div  <= div >> 1;
          step <= step + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // debounce counter
  always_comb begin
    deb_req.clear     = accept && score.operation == OP_CLEAR;
    deb_req.update    = fire;
    deb_req.hit       = hit_sum && code_ok;
    deb_req.verify_ok = item_ok;
  end

  wsd_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .hits_needed (hits_needed),
    .req         (deb_req),
    .res         (deb_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.smoothed_score <= mean;
      result.awake          <= deb_res.awake;
      result.rejected       <= deb_res.rejected;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_score_starts_sum: assert property (@(posedge clk) disable iff (rst)
    accept && score.operation == OP_SCORE |=> state == ST_SUM)
    else $error("score request did not start summing");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && score.operation == OP_CLEAR |=> fill_count == '0 && write_slot == '0)
    else $error("clear request left ring pointers");

  a_decision_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.awake && result.rejected))
    else $error("result both awake and rejected");

endmodule

`default_nettype wire

// File: verif/wake_score_smoother_debouncer_tb.sv
// self-checking testbench for the wake score smoother and debouncer
`timescale 1ns / 1ps

module wake_score_smoother_debouncer_tb;
  import wsd_pkg::*;

  // mirror of the smoothing window and hit counter, with the decisions still owed
  class wake_decision_checker;
    logic signed [SCORE_W-1:0] ring [WINDOW_DEF];
    int slot;
    int fill;
    int hit_run;
    int zero_pt;
    int thresh;
    int margin;
    int need;
    result_t pending_decisions [$];
    int errors;

    function new();
      zero_pt = -128;
      thresh  = 128;
      margin  = 0;
      need    = 3;
      slot    = 0;
      fill    = 0;
      hit_run = 0;
      errors  = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_CODE_OFFSET:    zero_pt = $signed(data[7:0]);
        CFG_WAKE_THRESHOLD: thresh  = $signed(data);
        CFG_KEYWORD_MARGIN: margin  = data[7:0];
        CFG_HITS_NEEDED:    need    = data[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_decisions.size();
    endfunction

    // work out the decision that an accepted request owes
    function void note_request(score_t req);
      int kw;
      int total;
      bit hit;
      result_t decision;
      if (req.operation == OP_CLEAR) begin
        slot    = 0;
        fill    = 0;
        hit_run = 0;
        return;
      end
      kw = $signed(req.keyword_code);
      ring[slot] = SCORE_W'(kw - zero_pt);
      slot = (slot + 1) % WINDOW_DEF;
      if (fill < WINDOW_DEF) fill++;
      total = 0;
      for (int i = 0; i < fill; i++) total += ring[i];
      hit = (total >= thresh * fill) && (kw >= $signed(req.unknown_code) + margin)
            && (kw >= $signed(req.silence_code));
      // consecutive hits, saturating
      if (!hit) hit_run = 0;
      else if (hit_run < int'(HIT_MAX)) hit_run++;
      decision.smoothed_score = SCORE_W'(total / fill);
      decision.awake    = (hit_run >= need) && req.verify_ok;
      decision.rejected = (hit_run >= need) && !req.verify_ok;
      pending_decisions.push_back(decision);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $time, what);
    endfunction

    // compare a delivered result with the oldest owed decision
    function void check_result(result_t got);
      result_t want;
      if (pending_decisions.size() == 0) begin
        flag($sformatf("unexpected result score=%0d awake=%0b rejected=%0b",
                       got.smoothed_score, got.awake, got.rejected));
        return;
      end
      want = pending_decisions.pop_front();
      if (got.smoothed_score !== want.smoothed_score)
        flag($sformatf("smoothed_score expected %0d got %0d",
                       want.smoothed_score, got.smoothed_score));
      if (got.awake !== want.awake)
        flag($sformatf("awake expected %0b got %0b", want.awake, got.awake));
      if (got.rejected !== want.rejected)
        flag($sformatf("rejected expected %0b got %0b", want.rejected, got.rejected));
    endfunction
  endclass

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             score_valid  = 1'b0;
  logic             score_stall;
  score_t           score_req    = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result_out;
  logic             cfg_we       = 1'b0;
  cfg_index_t       cfg_index    = CFG_CODE_OFFSET;
  logic [CFG_W-1:0] cfg_data     = '0;

  bit sender_quiet = 1'b0;
  bit hold_off     = 1'b0;
  wake_decision_checker board;

  wake_score_smoother_debouncer u_dut (
    .clk          (clk),
    .rst          (rst),
    .score_valid  (score_valid),
    .score_stall  (score_stall),
    .score        (score_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic score_t make_score(op_t op, int kw, int un, int si, bit ok);
    score_t s;
    s.operation    = op;
    s.keyword_code = 8'(kw);
    s.unknown_code = 8'(un);
    s.silence_code = 8'(si);
    s.verify_ok    = ok;
    return s;
  endfunction

  function automatic int cap(int v, int c);
    return (v < c) ? v : c;
  endfunction

  // keyword-led request that mostly clears the margin and silence tests
  function automatic score_t hit_candidate(int mg);
    int kw;
    int un_hi;
    int un;
    int si;
    kw    = 127 - $urandom_range(0, cap(255 - mg, 40));
    un_hi = kw - mg;
    un    = un_hi - $urandom_range(0, cap(un_hi + 128, 20));
    // near misses on either side test
    if ($urandom_range(0, 7) == 0 && un_hi < 127) un = un_hi + 1;
    si = kw - $urandom_range(0, cap(kw + 128, 60));
    if ($urandom_range(0, 9) == 0 && kw < 127) si = kw + 1;
    return make_score(OP_SCORE, kw, un, si, $urandom_range(0, 3) != 0);
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(score_t req);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      score_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    score_req   <= req;
    score_valid <= 1'b1;
    do @(posedge clk); while (score_stall);
    board.note_request(req);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk);
    score_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  // registers change only once the block is idle, after every owed result is delivered
  task automatic apply_config(int zp, int thr, int mg, int nd);
    wait_drained();
    repeat (25) @(posedge clk);
    write_reg(CFG_CODE_OFFSET, {1'($urandom), 8'(zp)});
    write_reg(CFG_WAKE_THRESHOLD, 9'(thr));
    write_reg(CFG_KEYWORD_MARGIN, {1'($urandom), 8'(mg)});
    write_reg(CFG_HITS_NEEDED, {5'($urandom), 4'(nd)});
  endtask

  // runs of keyword-led requests broken by noise and clears
  task automatic run_random(int count);
    int streak;
    bit hitting;
    streak  = 0;
    hitting = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
      if (streak == 0) begin
        hitting = ($urandom_range(0, 9) < 7);
        streak  = hitting ? $urandom_range(1, 20) : $urandom_range(1, 6);
      end
      streak--;
      if ($urandom_range(0, 24) == 0)
        send_request(make_score(OP_CLEAR, $urandom, $urandom, $urandom, 1'($urandom)));
      else if (hitting)
        send_request(hit_candidate(board.margin));
      else
        send_request(make_score(OP_SCORE, $urandom, $urandom, $urandom, 1'($urandom)));
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int gap;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      taken++;
      if (hold_off) begin
        gap      = 300;
        hold_off = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        @(negedge clk);
        result_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      board.check_result(result_out);
    end
  end

  initial begin : stimulus
    int zp;
    int thr;
    int mg;
    int nd;
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: build up to awake, then verifier refusal
    repeat (3) send_request(make_score(OP_SCORE, 127, -128, -128, 1'b1));
    send_request(make_score(OP_SCORE, 127, -128, -128, 1'b0));
    // keyword equal to unknown and to silence still counts
    send_request(make_score(OP_SCORE, 127, 127, 127, 1'b1));
    // margin test fails, then silence test fails
    send_request(make_score(OP_SCORE, -128, 127, -128, 1'b1));
    send_request(make_score(OP_SCORE, 126, -128, 127, 1'b1));
    send_request(make_score(OP_CLEAR, 85, -86, 85, 1'b0));
    send_request(make_score(OP_SCORE, -128, -128, -128, 1'b0));
    // wrap the window with alternating extremes
    for (int i = 0; i < 10; i++)
      send_request(make_score(OP_SCORE, (i % 2) ? -128 : 127, -1, -2, i % 3 != 0));
    send_request(make_score(OP_CLEAR, -86, 85, -86, 1'b1));
    // mean exactly on the threshold after a clear
    send_request(make_score(OP_SCORE, 0, 0, 0, 1'b1));

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: apply_config(127, -255, 255, 15);
        2: apply_config(-128, 255, 0, 1);
        3: apply_config(0, 0, 0, 0);
        5, 7: apply_config($urandom_range(0, 255) - 128, $urandom_range(0, 510) - 255,
                           $urandom_range(0, 255), $urandom_range(0, 15));
        default: begin
          zp  = $urandom_range(0, 255) - 128;
          thr = 70 - zp - $urandom_range(0, 80);
          mg  = $urandom_range(0, 30);
          nd  = $urandom_range(1, 15);
          apply_config(zp, thr, mg, nd);
        end
      endcase
      // long result hold-off so the block backs up onto its input
      if (ph == 2 || ph == 6) hold_off = 1'b1;
      run_random(71);
      wait_drained();
      run_random(72);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("[wake_score_smoother_debouncer] OK");
    end else begin
      $display("[wake_score_smoother_debouncer] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[wake_score_smoother_debouncer] ERROR");
    $finish;
  end

endmodule
